### design/spq_pkg.sv
// Package for the sorted priority queue: request and status codes, field widths,
// the sequencer state type and the control word broadcast to the cell chain.
// No dependencies.
package spq_pkg;

  localparam int DEPTH_DEF       = 16;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam int FUNC_W  = 3;
  localparam int ITEM_W  = 32;
  localparam int POS_W   = 4;
  localparam int RES_W   = 32;
  localparam int STAT_W  = 2;
  localparam int CNT_W   = 5;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 48;

  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT       = 3'd0,
    FN_DELETE       = 3'd1,
    FN_EXTRACT_AT   = 3'd2,
    FN_EXTRACT_LAST = 3'd3,
    FN_SEARCH       = 3'd4,
    FN_READ_AT      = 3'd5
  } func_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_RANGE     = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    SQ_IDLE,
    SQ_CMP,
    SQ_APPLY
  } seq_state_e;

  typedef struct packed {
    logic  cmp;
    logic  apply;
    func_e func;
    logic  found;
    logic  hit;
    logic  full;
  } cell_ctl_t;

endpackage

### design/sorted_priority_queue.sv
// Sorted priority queue: a chain of compare-and-shift cells kept in ascending order.
// Steps: capture, compare in every cell, then shift and register the result beat.
// A new request is taken only after the shift step, which waits on output back-pressure.
// The next request is taken while a result beat still waits on the output register.
// Reset: asynchronous, active low; clears the count, all cell valid bits and the sequencer.
// Depends on spq_pkg and spq_cell.
module sorted_priority_queue #(
  parameter int DEPTH       = spq_pkg::DEPTH_DEF,
  parameter int VALUE_WIDTH = spq_pkg::VALUE_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // func [2:0], item_value [34:3], position [38:35], zero pad [39]
  input  logic [spq_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // result_value [31:0], found [32], status [34:33], entry_count [39:35],
  // is_empty [40], zero pad [47:41]
  output logic [spq_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

  localparam int CW  = $clog2(DEPTH + 1);
  localparam int PXW = (CW > spq_pkg::POS_W) ? CW : spq_pkg::POS_W;
  localparam int KXW = (VALUE_WIDTH > spq_pkg::ITEM_W) ? VALUE_WIDTH : spq_pkg::ITEM_W;
  localparam int CXW = (CW > spq_pkg::CNT_W) ? CW : spq_pkg::CNT_W;

  spq_pkg::seq_state_e state_q, state_d;
  spq_pkg::func_e      func_q;
  logic [VALUE_WIDTH-1:0]      key_q;
  logic [spq_pkg::POS_W-1:0]   pos_q;
  logic [CW-1:0]               count_q, count_d;
  logic                        in_beat, cmp_en, apply_en;
  logic                        m_valid_q;
  logic [spq_pkg::OUT_TDATA_W-1:0] m_data_q;

  logic [KXW-1:0]              key_x;
  logic [VALUE_WIDTH-1:0]      val   [DEPTH];
  logic [DEPTH-1:0]            valid, lt, eq, ge_pos, pick;
  logic                        found, hit, full;
  logic [VALUE_WIDTH-1:0]      pick_val;
  logic [KXW-1:0]              res_x;
  logic [CXW-1:0]              cnt_x;
  spq_pkg::cell_ctl_t          ctl;

  logic [spq_pkg::RES_W-1:0]   res_value;
  logic                        res_found;
  spq_pkg::status_e            res_status;

  // sequencer
  assign in_beat = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      spq_pkg::SQ_IDLE:  if (in_beat) state_d = spq_pkg::SQ_CMP;
      spq_pkg::SQ_CMP:   state_d = spq_pkg::SQ_APPLY;
      spq_pkg::SQ_APPLY: if (apply_en) state_d = spq_pkg::SQ_IDLE;
      default:           state_d = spq_pkg::SQ_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state_q == spq_pkg::SQ_IDLE);
    cmp_en        = (state_q == spq_pkg::SQ_CMP);
    apply_en      = (state_q == spq_pkg::SQ_APPLY) && (!m_valid_q || m_axis_tready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= spq_pkg::SQ_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  // capture request
  assign key_x = KXW'($signed(s_axis_tdata[34:3]));

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      func_q <= spq_pkg::func_e'(s_axis_tdata[2:0]);
      key_q  <= key_x[VALUE_WIDTH-1:0];
      pos_q  <= s_axis_tdata[38:35];
    end
  end

  // cell chain
  assign full  = (count_q == CW'(DEPTH));
  assign found = |eq;
  assign hit   = (func_q == spq_pkg::FN_EXTRACT_LAST) ? (count_q != '0)
                                                      : (PXW'(pos_q) < PXW'(count_q));

  always_comb begin
    ctl.cmp   = cmp_en;
    ctl.apply = apply_en;
    ctl.func  = func_q;
    ctl.found = found;
    ctl.hit   = hit;
    ctl.full  = full;
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [VALUE_WIDTH-1:0] lv, rv;
    logic                   lvd, llt, rvd;

    assign ge_pos[g] = (PXW'(g) >= PXW'(pos_q));

    if (g == 0) begin : g_head
      assign lv  = key_q;
      assign lvd = 1'b0;
      assign llt = 1'b1;
      assign pick[g] = (func_q == spq_pkg::FN_EXTRACT_LAST) ? (valid[g] && !rvd)
                                                            : ge_pos[g];
    end else begin : g_body
      assign lv  = val[g-1];
      assign lvd = valid[g-1];
      assign llt = lt[g-1];
      assign pick[g] = (func_q == spq_pkg::FN_EXTRACT_LAST) ? (valid[g] && !rvd)
                                                            : (ge_pos[g] && !ge_pos[g-1]);
    end

    if (g == DEPTH - 1) begin : g_tail
      assign rv  = val[g];
      assign rvd = 1'b0;
    end else begin : g_mid
      assign rv  = val[g+1];
      assign rvd = valid[g+1];
    end

    spq_cell #(
      .VALUE_WIDTH(VALUE_WIDTH)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .key_i        (key_q),
      .ge_pos_i     (ge_pos[g]),
      .left_val_i   (lv),
      .left_valid_i (lvd),
      .left_lt_i    (llt),
      .right_val_i  (rv),
      .right_valid_i(rvd),
      .val_o        (val[g]),
      .valid_o      (valid[g]),
      .lt_o         (lt[g]),
      .eq_o         (eq[g])
    );
  end

  always_comb begin
    pick_val = '0;
    for (int i = 0; i < DEPTH; i++) begin
      pick_val = pick_val | (pick[i] ? val[i] : '0);
    end
  end

  assign res_x = KXW'($signed(pick_val));

  // result and count update
  always_comb begin
    res_value  = '0;
    res_found  = 1'b0;
    res_status = spq_pkg::ST_OK;
    count_d    = count_q;
    case (func_q)
      spq_pkg::FN_INSERT: begin
        if (full) begin
          res_status = spq_pkg::ST_FULL;
        end else if (apply_en) begin
          count_d = count_q + CW'(1);
        end
      end
      spq_pkg::FN_DELETE, spq_pkg::FN_SEARCH: begin
        res_found  = found;
        res_status = found ? spq_pkg::ST_OK : spq_pkg::ST_NOT_FOUND;
        if (found && apply_en && (func_q == spq_pkg::FN_DELETE)) begin
          count_d = count_q - CW'(1);
        end
      end
      spq_pkg::FN_EXTRACT_AT, spq_pkg::FN_READ_AT, spq_pkg::FN_EXTRACT_LAST: begin
        if (hit) begin
          res_value = res_x[spq_pkg::RES_W-1:0];
          if (apply_en && (func_q != spq_pkg::FN_READ_AT)) begin
            count_d = count_q - CW'(1);
          end
        end else begin
          res_status = spq_pkg::ST_RANGE;
        end
      end
      default: ;
    endcase
  end

  assign cnt_x = CXW'(count_d);

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (apply_en) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (apply_en) begin
      m_data_q <= {7'd0, (count_d == '0), cnt_x[spq_pkg::CNT_W-1:0], res_status,
                   res_found, res_value};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count above depth");

  a_valid_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid) == int'(count_q))
    else $error("valid cells disagree with entry count");

  a_valid_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid[DEPTH-1:1] & ~valid[DEPTH-2:0]) == '0)
    else $error("gap in valid cells");

  a_cmp_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == spq_pkg::SQ_CMP) |=> ($stable(count_q) && $stable(valid)))
    else $error("queue changed during compare pass");

endmodule

### design/spq_cell.sv
// One cell of the sorted queue chain: a stored value, its valid bit and the
// compare flags against the broadcast key. Shifts toward either neighbor.
// Depends on spq_pkg.
module spq_cell #(
  parameter int VALUE_WIDTH = spq_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  spq_pkg::cell_ctl_t     ctl_i,
  input  logic [VALUE_WIDTH-1:0] key_i,
  input  logic                   ge_pos_i,
  input  logic [VALUE_WIDTH-1:0] left_val_i,
  input  logic                   left_valid_i,
  input  logic                   left_lt_i,
  input  logic [VALUE_WIDTH-1:0] right_val_i,
  input  logic                   right_valid_i,
  output logic [VALUE_WIDTH-1:0] val_o,
  output logic                   valid_o,
  output logic                   lt_o,
  output logic                   eq_o
);

  logic [VALUE_WIDTH-1:0] val_q, val_d;
  logic                   valid_q, valid_d;
  logic                   lt_q, eq_q;

  always_comb begin
    val_d   = val_q;
    valid_d = valid_q;
    if (ctl_i.apply) begin
      case (ctl_i.func)
        spq_pkg::FN_INSERT: begin
          if (!ctl_i.full && !lt_q) begin
            if (left_lt_i) begin
              val_d   = key_i;
              valid_d = 1'b1;
            end else begin
              val_d   = left_val_i;
              valid_d = left_valid_i;
            end
          end
        end
        spq_pkg::FN_DELETE: begin
          if (ctl_i.found && !lt_q) begin
            val_d   = right_val_i;
            valid_d = right_valid_i;
          end
        end
        spq_pkg::FN_EXTRACT_AT: begin
          if (ctl_i.hit && ge_pos_i) begin
            val_d   = right_val_i;
            valid_d = right_valid_i;
          end
        end
        spq_pkg::FN_EXTRACT_LAST: begin
          if (!right_valid_i) begin
            val_d   = right_val_i;
            valid_d = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    if (ctl_i.cmp) begin
      lt_q <= valid_q && ($signed(val_q) < $signed(key_i));
      eq_q <= valid_q && (val_q == key_i);
    end
  end

  assign val_o   = val_q;
  assign valid_o = valid_q;
  assign lt_o    = lt_q;
  assign eq_o    = eq_q;

endmodule

### sim/tb_top.sv
// Testbench for sorted_priority_queue: directed and random requests on the input
// stream, each result beat checked against a behavioral sorted-list predictor.
// Depends on spq_pkg and the sorted_priority_queue RTL.
`timescale 1ns / 100ps

module tb_top;

  localparam int QDEPTH = spq_pkg::DEPTH_DEF;
  localparam logic [spq_pkg::FUNC_W-1:0] FN_SPARE_6 = 3'd6;
  localparam logic [spq_pkg::FUNC_W-1:0] FN_SPARE_7 = 3'd7;
  localparam int PH_FILL  = 0;
  localparam int PH_DRAIN = 1;
  localparam int PH_MIXED = 2;

  typedef struct {
    logic [spq_pkg::FUNC_W-1:0] fn;
    logic [spq_pkg::ITEM_W-1:0] value;
    logic [spq_pkg::POS_W-1:0]  pos;
    bit                         drain_first;
  } request_t;

  typedef struct {
    logic signed [spq_pkg::RES_W-1:0] value;
    logic                             found;
    logic [spq_pkg::STAT_W-1:0]       status;
    logic [spq_pkg::CNT_W-1:0]        count;
    logic                             empty;
  } result_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [spq_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [spq_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

  request_t                          req_q[$];
  result_t                           due_results[$];
  logic signed [spq_pkg::ITEM_W-1:0] sorted_vals[$];
  logic                              in_taken = 1'b0;
  int                                beats_in = 0;
  int                                mismatches = 0;
  logic [spq_pkg::ITEM_W-1:0]        value_pool[8] = '{32'h0000_0000, 32'h0001_0000,
                                                       32'hFFFF_0000, 32'h0000_8000,
                                                       32'h7FFF_FFFF, 32'h8000_0000,
                                                       32'h0003_0000, 32'hFFFD_0000};
  wire                               calm = (beats_in >= 200) && (beats_in < 320);

  sorted_priority_queue dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic result_t apply_queue_op(logic [spq_pkg::FUNC_W-1:0] fn,
                                             logic signed [spq_pkg::ITEM_W-1:0] v,
                                             logic [spq_pkg::POS_W-1:0] pos);
    result_t r;
    int      p;
    r = '{value: '0, found: 1'b0, status: spq_pkg::ST_OK, count: '0, empty: 1'b0};
    p = 0;
    case (fn)
      spq_pkg::FN_INSERT: begin
        if (sorted_vals.size() >= QDEPTH) begin
          r.status = spq_pkg::ST_FULL;
        end else begin
          while (p < sorted_vals.size() && sorted_vals[p] < v) p++;
          sorted_vals.insert(p, v);
        end
      end
      spq_pkg::FN_DELETE, spq_pkg::FN_SEARCH: begin
        r.status = spq_pkg::ST_NOT_FOUND;
        for (int i = 0; i < sorted_vals.size(); i++) begin
          if (sorted_vals[i] == v) begin
            r.found  = 1'b1;
            r.status = spq_pkg::ST_OK;
            if (fn == spq_pkg::FN_DELETE) sorted_vals.delete(i);
            break;
          end
        end
      end
      spq_pkg::FN_EXTRACT_AT, spq_pkg::FN_READ_AT: begin
        if (pos >= sorted_vals.size()) begin
          r.status = spq_pkg::ST_RANGE;
        end else begin
          r.value = sorted_vals[pos];
          if (fn == spq_pkg::FN_EXTRACT_AT) sorted_vals.delete(pos);
        end
      end
      spq_pkg::FN_EXTRACT_LAST: begin
        if (sorted_vals.size() == 0) begin
          r.status = spq_pkg::ST_RANGE;
        end else begin
          r.value = sorted_vals.pop_back();
        end
      end
      default: ;
    endcase
    r.count = spq_pkg::CNT_W'(sorted_vals.size());
    r.empty = (sorted_vals.size() == 0);
    return r;
  endfunction

  task automatic check_field(string fname, longint want_v, longint got_v);
    if (want_v != got_v) begin
      $error("%s mismatch: expected %0d, got %0d", fname, want_v, got_v);
      mismatches++;
    end
  endtask

  task automatic add_req(logic [spq_pkg::FUNC_W-1:0] fn, logic [spq_pkg::ITEM_W-1:0] v,
                         logic [spq_pkg::POS_W-1:0] pos, bit drain_first = 1'b0);
    request_t rq;
    rq = '{fn: fn, value: v, pos: pos, drain_first: drain_first};
    req_q.push_back(rq);
  endtask

  function automatic logic [spq_pkg::FUNC_W-1:0] pick_func(int phase_kind);
    int roll;
    roll = $urandom_range(99);
    if (roll < 3) return (roll == 0) ? FN_SPARE_7 : FN_SPARE_6;
    case (phase_kind)
      PH_FILL: begin
        if (roll < 78) return spq_pkg::FN_INSERT;
        return spq_pkg::FUNC_W'($urandom_range(5));
      end
      PH_DRAIN: begin
        if (roll < 18) return spq_pkg::FN_INSERT;
        if (roll < 40) return spq_pkg::FN_DELETE;
        if (roll < 60) return spq_pkg::FN_EXTRACT_AT;
        if (roll < 80) return spq_pkg::FN_EXTRACT_LAST;
        if (roll < 90) return spq_pkg::FN_SEARCH;
        return spq_pkg::FN_READ_AT;
      end
      default:  return spq_pkg::FUNC_W'($urandom_range(5));
    endcase
  endfunction

  // drive requests and output back-pressure
  always @(negedge clk_i) begin
    if (rst_ni) begin
      m_axis_tready <= calm || ($urandom_range(99) >= 32);
      if (!s_axis_tvalid || in_taken) begin
        if (req_q.size() != 0 && !(req_q[0].drain_first && due_results.size() != 0)
            && (calm || $urandom_range(99) >= 32)) begin
          s_axis_tdata  <= {1'b0, req_q[0].pos, req_q[0].value, req_q[0].fn};
          s_axis_tvalid <= 1'b1;
          void'(req_q.pop_front());
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // predict on accepted requests, check result beats
  always @(posedge clk_i) begin : monitor
    result_t want;
    result_t got;
    in_taken <= s_axis_tvalid && s_axis_tready;
    if (s_axis_tvalid && s_axis_tready) begin
      want = apply_queue_op(s_axis_tdata[2:0], s_axis_tdata[34:3], s_axis_tdata[38:35]);
      due_results.push_back(want);
      beats_in++;
    end
    if (m_axis_tvalid && m_axis_tready) begin
      got.value  = m_axis_tdata[31:0];
      got.found  = m_axis_tdata[32];
      got.status = m_axis_tdata[34:33];
      got.count  = m_axis_tdata[39:35];
      got.empty  = m_axis_tdata[40];
      if (due_results.size() == 0) begin
        $error("result beat with no request pending");
        mismatches++;
      end else begin
        want = due_results.pop_front();
        check_field("result_value", want.value, got.value);
        check_field("found", want.found, got.found);
        check_field("status", want.status, got.status);
        check_field("entry_count", want.count, got.count);
        check_field("is_empty", want.empty, got.empty);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    int total;
    int phase;
    int phase_kind;
    int len;
    logic [spq_pkg::ITEM_W-1:0] v;
    logic [spq_pkg::POS_W-1:0]  pos;

    // empty-queue corners and spare function codes
    add_req(spq_pkg::FN_DELETE, 32'h0, 4'd0);
    add_req(spq_pkg::FN_EXTRACT_LAST, 32'h0, 4'd0);
    add_req(spq_pkg::FN_EXTRACT_AT, 32'h0, 4'd0);
    add_req(spq_pkg::FN_READ_AT, 32'h0, 4'd15);
    add_req(spq_pkg::FN_SEARCH, 32'h0, 4'd0);
    add_req(FN_SPARE_6, 32'hFFFF_FFFF, 4'd15);
    add_req(FN_SPARE_7, 32'h5555_AAAA, 4'd10);
    // extremes and equal keys, then lookups and removals on them
    add_req(spq_pkg::FN_INSERT, 32'h7FFF_FFFF, 4'd0);
    add_req(spq_pkg::FN_INSERT, 32'h8000_0000, 4'd0);
    add_req(spq_pkg::FN_INSERT, 32'h0, 4'd0);
    add_req(spq_pkg::FN_INSERT, 32'h0, 4'd5);
    add_req(spq_pkg::FN_INSERT, 32'h0001_0000, 4'd0);
    add_req(spq_pkg::FN_SEARCH, 32'h0, 4'd0);
    add_req(spq_pkg::FN_SEARCH, 32'hFFFF_0000, 4'd0);
    add_req(spq_pkg::FN_READ_AT, 32'h0, 4'd0);
    add_req(spq_pkg::FN_READ_AT, 32'h0, 4'd4);
    add_req(spq_pkg::FN_READ_AT, 32'h0, 4'd5);
    add_req(spq_pkg::FN_EXTRACT_AT, 32'h0, 4'd1);
    add_req(spq_pkg::FN_DELETE, 32'h7FFF_FFFF, 4'd0);
    add_req(spq_pkg::FN_DELETE, 32'h0000_3039, 4'd0);
    add_req(spq_pkg::FN_EXTRACT_LAST, 32'h0, 4'd0);
    add_req(spq_pkg::FN_EXTRACT_AT, 32'h0, 4'd15);
    add_req(spq_pkg::FN_INSERT, 32'hFFFE_8000, 4'd0);
    add_req(spq_pkg::FN_EXTRACT_LAST, 32'h0, 4'd0);

    total = req_q.size();
    phase = 0;
    while (total < 650) begin
      phase_kind = (phase == 0) ? PH_FILL : int'($urandom_range(PH_MIXED));
      len = (phase == 0) ? 40 : int'($urandom_range(20, 60));
      for (int i = 0; i < len; i++) begin
        v   = ($urandom_range(99) < 60) ? value_pool[$urandom_range(7)] : $urandom;
        pos = ($urandom_range(1) == 0) ? spq_pkg::POS_W'($urandom_range(15))
                                       : spq_pkg::POS_W'($urandom_range(7));
        add_req(pick_func(phase_kind), v, pos, (i == 0) && (phase % 3 == 0));
      end
      total += len;
      phase++;
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (req_q.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
design/spq_pkg.sv
design/spq_cell.sv
design/sorted_priority_queue.sv
sim/tb_top.sv
